// ----- design/esa_pkg.sv -----
// Shared definitions for the entity slot allocator: request and status codes,
// and the payload structures of the request and response channels.
// Depends on nothing; the two interfaces and the core import it.
`timescale 1ns / 1ps
`default_nettype none

package esa_pkg;

  localparam logic [2:0] REQ_CREATE = 3'd0;
  localparam logic [2:0] REQ_REMOVE = 3'd1;
  localparam logic [2:0] REQ_ATTACH = 3'd2;
  localparam logic [2:0] REQ_QUERY  = 3'd3;
  localparam logic [2:0] REQ_READ   = 3'd4;

  localparam logic [2:0] STS_OK        = 3'd0;
  localparam logic [2:0] STS_NO_FREE   = 3'd1;
  localparam logic [2:0] STS_BAD_ID    = 3'd2;
  localparam logic [2:0] STS_LIST_FULL = 3'd3;
  localparam logic [2:0] STS_NO_TAG    = 3'd4;

  typedef struct packed {
    logic [2:0] req_type;
    logic [5:0] entity_id;
    logic [7:0] tag_value;
    logic [2:0] tag_slot;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [5:0] granted_id;
    logic [6:0] free_count;
    logic [2:0] stored_slot;
    logic [7:0] read_tag;
  } rsp_t;

endpackage

`default_nettype wire

// ----- design/esa_req_if.sv -----
// Request channel of the entity slot allocator: valid/ready handshake and
// the request payload. Depends on esa_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface esa_req_if import esa_pkg::*;;
  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- design/esa_rsp_if.sv -----
// Response channel of the entity slot allocator: valid/ready handshake and
// the result payload. Depends on esa_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface esa_rsp_if import esa_pkg::*;;
  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- design/entity_slot_allocator_core.sv -----
// Entity slot allocator: hands out slot IDs from a fixed pool and keeps a
// short tag list for each live slot. A request is accepted in the idle
// state, in which the tag count and tag store memories are read; in the
// execute state the result is resolved, the memories and the slot bitmap
// are written back and the result beat is loaded into the output register.
// A new request is accepted only after the previous one has completed; a
// result waiting in the output register does not stop the next request from
// being accepted, only from completing. No clearing pass is needed after
// reset, since a slot's tag count is cleared whenever the slot is created.
// Depends on esa_pkg, esa_req_if, esa_rsp_if and esa_ram.
`timescale 1ns / 1ps
`default_nettype none

module entity_slot_allocator_core import esa_pkg::*; #(
  parameter int NUM_SLOTS     = 64,
  parameter int TAGS_PER_SLOT = 8,
  parameter int TAG_BITS      = 8
) (
  input wire logic clk,
  input wire logic rst,
  esa_req_if.sink   req,
  esa_rsp_if.source rsp
);

  localparam int SLOT_W = $clog2(NUM_SLOTS);
  localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
  localparam int TCNT_W = $clog2(TAGS_PER_SLOT + 1);
  localparam int ADDR_W = $clog2(NUM_SLOTS * TAGS_PER_SLOT);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic                 state;
  req_t                 req_q;
  logic [NUM_SLOTS-1:0] used;
  logic [NUM_SLOTS-1:0] used_next;
  logic [CNT_W-1:0]     live;
  logic [CNT_W-1:0]     live_next;
  logic                 out_valid;
  rsp_t                 out_data;

  logic              fire;
  logic [5:0]        cur_id;
  logic [2:0]        cur_pos;
  logic [SLOT_W+5:0] id_x;
  logic [SLOT_W-1:0] id_idx;
  logic              id_in_range;
  logic              id_live;
  logic [TCNT_W+2:0] pos_x;
  logic              pos_in_list;

  logic [TCNT_W-1:0]   cnt_rdata;
  logic [TCNT_W+2:0]   cnt_x;
  logic                cnt_full;
  logic                tag_missing;
  logic [TAG_BITS-1:0] tag_rdata;
  logic [ADDR_W-1:0]   id_base;
  logic [ADDR_W-1:0]   tag_raddr;
  logic [ADDR_W-1:0]   tag_waddr;
  logic [TAG_BITS+7:0] tag_in_x;

  logic [SLOT_W-1:0] low_free;
  logic [SLOT_W-1:0] live_idx;
  logic              pool_full;
  logic [SLOT_W-1:0] pick;

  logic [2:0]          sts;
  logic [SLOT_W-1:0]   grant_idx;
  logic [TCNT_W-1:0]   stored_cnt;
  logic [TAG_BITS-1:0] rtag;
  logic                cnt_we;
  logic [SLOT_W-1:0]   cnt_waddr;
  logic [TCNT_W-1:0]   cnt_wdata;
  logic                tag_we;
  logic [CNT_W-1:0]    free_cnt;
  logic [SLOT_W+5:0]   grant_x;
  logic [TCNT_W+2:0]   stored_x;
  logic [CNT_W+6:0]    free_x;
  logic [TAG_BITS+7:0] rtag_x;

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  // The result may only be loaded when the output register is empty or is
  // being emptied in this cycle.
  assign fire = (state == S_EXEC) && (!out_valid || rsp.ready);

  // In the idle state the memories are addressed straight from the request
  // port; while a request waits to complete, from its held copy.
  assign cur_id  = (state == S_IDLE) ? req.data.entity_id : req_q.entity_id;
  assign cur_pos = (state == S_IDLE) ? req.data.tag_slot : req_q.tag_slot;

  assign id_x        = {{SLOT_W{1'b0}}, cur_id};
  assign id_idx      = id_x[SLOT_W-1:0];
  assign id_in_range = (id_x < (SLOT_W + 6)'(NUM_SLOTS));
  assign id_live     = id_in_range && used[id_idx];

  assign pos_x       = {{TCNT_W{1'b0}}, cur_pos};
  assign pos_in_list = (pos_x < (TCNT_W + 3)'(TAGS_PER_SLOT));

  assign id_base   = ADDR_W'(id_idx) * ADDR_W'(TAGS_PER_SLOT);
  assign tag_raddr = pos_in_list ? (id_base + ADDR_W'(cur_pos)) : id_base;
  assign tag_waddr = id_base + ADDR_W'(cnt_rdata);
  assign tag_in_x  = {{TAG_BITS{1'b0}}, req_q.tag_value};

  esa_ram #(
    .WIDTH (TCNT_W),
    .DEPTH (NUM_SLOTS)
  ) u_count_ram (
    .clk   (clk),
    .we    (cnt_we && fire),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (id_idx),
    .rdata (cnt_rdata)
  );

  esa_ram #(
    .WIDTH (TAG_BITS),
    .DEPTH (NUM_SLOTS * TAGS_PER_SLOT)
  ) u_tag_ram (
    .clk   (clk),
    .we    (tag_we && fire),
    .waddr (tag_waddr),
    .wdata (tag_in_x[TAG_BITS-1:0]),
    .raddr (tag_raddr),
    .rdata (tag_rdata)
  );

  assign cnt_x       = {3'b000, cnt_rdata};
  assign cnt_full    = (cnt_x >= (TCNT_W + 3)'(TAGS_PER_SLOT));
  assign tag_missing = (pos_x >= cnt_x) || !pos_in_list;

  // Lowest free slot: a priority encoder over the used bitmap.
  always_comb begin
    low_free = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!used[i]) begin
        low_free = SLOT_W'(i);
      end
    end
  end

  assign pool_full = (live == CNT_W'(NUM_SLOTS));
  assign live_idx  = live[SLOT_W-1:0];
  assign pick      = used[live_idx] ? low_free : live_idx;

  always_comb begin
    sts        = STS_OK;
    grant_idx  = '0;
    stored_cnt = '0;
    rtag       = '0;
    used_next  = used;
    live_next  = live;
    cnt_we     = 1'b0;
    cnt_waddr  = id_idx;
    cnt_wdata  = cnt_rdata + TCNT_W'(1);
    tag_we     = 1'b0;
    case (req_q.req_type)
      REQ_CREATE: begin
        if (pool_full) begin
          sts = STS_NO_FREE;
        end else begin
          used_next[pick] = 1'b1;
          live_next       = live + CNT_W'(1);
          cnt_we          = 1'b1;
          cnt_waddr       = pick;
          cnt_wdata       = '0;
          grant_idx       = pick;
        end
      end
      REQ_REMOVE: begin
        if (!id_live) begin
          sts = STS_BAD_ID;
        end else begin
          used_next[id_idx] = 1'b0;
          live_next         = live - CNT_W'(1);
        end
      end
      REQ_ATTACH: begin
        if (!id_live) begin
          sts = STS_BAD_ID;
        end else if (cnt_full) begin
          sts = STS_LIST_FULL;
        end else begin
          cnt_we     = 1'b1;
          tag_we     = 1'b1;
          stored_cnt = cnt_rdata;
        end
      end
      REQ_READ: begin
        if (!id_live) begin
          sts = STS_BAD_ID;
        end else if (tag_missing) begin
          sts = STS_NO_TAG;
        end else begin
          rtag = tag_rdata;
        end
      end
      default: begin
        // Query and unused codes leave the state alone.
      end
    endcase
  end

  assign free_cnt = CNT_W'(NUM_SLOTS) - live_next;
  assign grant_x  = {6'b000000, grant_idx};
  assign stored_x = {3'b000, stored_cnt};
  assign free_x   = {7'b0000000, free_cnt};
  assign rtag_x   = {8'b00000000, rtag};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      used      <= '0;
      live      <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (fire) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (fire) begin
        used      <= used_next;
        live      <= live_next;
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      req_q <= req.data;
    end
    if (fire) begin
      out_data.status      <= sts;
      out_data.granted_id  <= grant_x[5:0];
      out_data.free_count  <= free_x[6:0];
      out_data.stored_slot <= stored_x[2:0];
      out_data.read_tag    <= rtag_x[7:0];
    end
  end

endmodule

`default_nettype wire

// ----- design/esa_ram.sv -----
// Generic simple dual-port RAM with one write port and one registered read
// port. Stand-alone; used for the tag counts and the tag store.
`timescale 1ns / 1ps
`default_nettype none

module esa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
